>>> rtl/rpn_pkg.sv
// ----------------------------------------------------------------------------
// RPN calculator package
// Command codes, status codes and the operand/result word type.
// ----------------------------------------------------------------------------
package rpn_pkg;

    localparam int unsigned CmdWidth  = 4;
    localparam int unsigned WordWidth = 32;
    localparam int unsigned StWidth   = 3;

    typedef logic signed [WordWidth-1:0] t_word;

    typedef enum logic [CmdWidth-1:0] {
        CMD_PUSH    = 4'd0,
        CMD_ADD     = 4'd1,
        CMD_SUB     = 4'd2,
        CMD_MUL     = 4'd3,
        CMD_DIV     = 4'd4,
        CMD_PEEK    = 4'd5,
        CMD_SWAP    = 4'd6,
        CMD_DUP     = 4'd7,
        CMD_CLEAR   = 4'd8,
        CMD_POPSHOW = 4'd9
    } t_cmd;

    typedef enum logic [StWidth-1:0] {
        ST_OK      = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_FULL    = 3'd2,
        ST_ZERODIV = 3'd3,
        ST_UNKNOWN = 3'd4
    } t_status;

    // Saturate a 64-bit signed value to the 32-bit word range.
    function automatic t_word sat_word(input logic signed [63:0] v);
        t_word r;
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[WordWidth-1:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/rpn_ram.sv
// ----------------------------------------------------------------------------
// RPN generic RAM
// Single-port write, single-port read, registered read data.
// ----------------------------------------------------------------------------
module rpn_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/rpn_div.sv
// ----------------------------------------------------------------------------
// RPN fixed-point divider
// Restoring divide, one quotient bit a cycle, truncating toward zero,
// saturated to the word range.
// ----------------------------------------------------------------------------
module rpn_div #(
    parameter int unsigned FRACTION_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  rpn_pkg::t_word i_a,
    input  rpn_pkg::t_word i_b,
    output logic          o_done,
    output rpn_pkg::t_word o_q
);
    import rpn_pkg::*;

    localparam int unsigned NumBits = WordWidth + FRACTION_BITS;
    localparam int unsigned CntW    = $clog2(NumBits + 1);

    logic [NumBits-1:0]   r_num;     // shifts out dividend bits, shifts in quotient
    logic [WordWidth:0]   r_rem;
    logic [WordWidth-1:0] r_den;
    logic                 r_neg;
    logic [CntW-1:0]      r_cnt;
    logic                 r_busy;
    logic                 r_done;
    t_word                r_q;

    logic [WordWidth:0]   rem_sh;
    logic [WordWidth:0]   rem_sub;
    logic [NumBits:0]     mag_q;
    logic signed [63:0]   sq;

    assign rem_sh  = {r_rem[WordWidth-1:0], r_num[NumBits-1]};
    assign rem_sub = rem_sh - {1'b0, r_den};
    assign mag_q   = {1'b0, r_num[NumBits-2:0], ~rem_sub[WordWidth]};
    assign sq      = r_neg ? -$signed(64'(mag_q)) : $signed(64'(mag_q));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CntW'(NumBits);
                r_rem  <= '0;
                r_neg  <= i_a[WordWidth-1] ^ i_b[WordWidth-1];
                r_den  <= i_b[WordWidth-1] ? 32'(-i_b) : i_b;
                r_num  <= NumBits'({i_a[WordWidth-1] ? 32'(-i_a) : 32'(i_a)})
                          << FRACTION_BITS;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                r_rem <= rem_sub[WordWidth] ? rem_sh : rem_sub;
                r_num <= mag_q[NumBits-1:0];
                if (r_cnt == CntW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_q    <= sat_word(sq);
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;
endmodule

>>> rtl/rpn_stack_calculator.sv
// ----------------------------------------------------------------------------
// RPN stack calculator
// Reverse Polish evaluator on a stack of saturating signed fixed-point words.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_axis_*: one transaction per command. tdata holds
//   command in bits [3:0] and number in bits [35:4] (padded to 40 bits).
//   Master channel m_axis_*: one transaction per command with shown_value,
//   value_shown, status and stack_depth.
//   The stack lives in a RAM with registered read data. A command pops up
//   to two entries (issue read, then take data, for each), computes, then
//   writes back up to two entries and loads the output register. A divide
//   spends most of its time in the bit-serial divider.
//   One command is in flight at a time; a new one is taken in idle even
//   while the previous result still waits in the output register.
//   Reset empties the stack (pointer to zero); RAM contents stay undefined
//   and are never read below the pointer before being written.
//   A stalled receiver holds the result in the output register; the next
//   command runs to completion and then waits until that register drains.
// ----------------------------------------------------------------------------
module rpn_stack_calculator #(
    parameter int unsigned STACK_DEPTH   = 128,
    parameter int unsigned FRACTION_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [3:0] command, [35:4] number
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // [31:0] shown_value, [32] value_shown,
                                        // [35:33] status, [43:36] stack_depth
);
    import rpn_pkg::*;

    localparam int unsigned AW = $clog2(STACK_DEPTH);
    localparam int unsigned PW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_POP1 = 10'b00_0000_0010,   // issue read of top entry
        S_GET1 = 10'b00_0000_0100,   // take top entry
        S_POP2 = 10'b00_0000_1000,   // issue read of second entry
        S_GET2 = 10'b00_0001_0000,   // take second entry
        S_EXEC = 10'b00_0010_0000,   // compute, first push
        S_MULW = 10'b00_0100_0000,   // product registered, push it
        S_DIVW = 10'b00_1000_0000,   // divider running
        S_WR2  = 10'b01_0000_0000,   // second push of swap/dup
        S_OUT  = 10'b10_0000_0000    // load the output register
    } t_state;

    t_state              r_state;
    logic [CmdWidth-1:0] r_cmd;
    t_word               r_num, r_a, r_b, r_w2, r_shown;
    logic [PW-1:0]       r_sp;
    t_status             r_st;
    logic                r_has;
    logic                r_hit;
    logic                r_ovalid;
    logic [47:0]         r_odata;
    logic signed [63:0]  r_prod;

    logic           we;
    logic [AW-1:0]  waddr, raddr;
    t_word          wdata, rdata;
    logic           div_start, div_done;
    t_word          div_q;
    t_word          pop_data;
    logic           push_req;
    t_word          push_val;

    rpn_ram #(.WIDTH(WordWidth), .DEPTH(STACK_DEPTH)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    rpn_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_a(r_a), .i_b(r_b), .o_done(div_done), .o_q(div_q)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    logic acc;
    assign acc = s_axis_tvalid && s_axis_tready;

    logic signed [63:0] sum_w, dif_w, prod_w;
    logic signed [63:0] mul_sh;
    assign sum_w  = 64'(r_a) + 64'(r_b);
    assign dif_w  = 64'(r_a) - 64'(r_b);
    assign prod_w = r_a * r_b;
    assign mul_sh = r_prod >>> FRACTION_BITS;   // floor

    // A missing operand reads as zero.
    assign pop_data = r_hit ? rdata : '0;

    logic push_ok;
    assign push_ok = r_sp < PW'(STACK_DEPTH);

    // Push requests by state; the write lands at the pointer.
    always_comb begin
        push_req = 1'b0;
        push_val = r_w2;
        unique case (r_state)
            S_EXEC: begin
                unique case (r_cmd)
                    CMD_PUSH: begin
                        push_req = 1'b1;
                        push_val = r_num;
                    end
                    CMD_ADD: begin
                        push_req = 1'b1;
                        push_val = sat_word(sum_w);
                    end
                    CMD_SUB: begin
                        push_req = 1'b1;
                        push_val = sat_word(dif_w);
                    end
                    CMD_SWAP: begin
                        push_req = 1'b1;
                        push_val = r_b;
                    end
                    CMD_DUP: begin
                        push_req = 1'b1;
                        push_val = r_a;
                    end
                    default: ;
                endcase
            end
            S_MULW: begin
                push_req = 1'b1;
                push_val = sat_word(mul_sh);
            end
            S_DIVW: begin
                push_req = div_done;
                push_val = div_q;
            end
            S_WR2: begin
                push_req = 1'b1;
            end
            default: ;
        endcase
    end

    assign we        = push_req && push_ok;
    assign waddr     = r_sp[AW-1:0];
    assign wdata     = push_val;
    assign raddr     = AW'(r_sp - 1'b1);
    assign div_start = (r_state == S_EXEC) && (r_cmd == CMD_DIV);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_sp     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            // Load a finished result or drop the one just taken.
            if (r_state == S_OUT && (!r_ovalid || m_axis_tready)) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        r_cmd   <= s_axis_tdata[3:0];
                        r_num   <= s_axis_tdata[35:4];
                        r_st    <= ST_OK;
                        r_has   <= 1'b0;
                        r_shown <= '0;
                        r_a     <= '0;
                        r_b     <= '0;
                        r_state <= S_POP1;
                    end
                end
                S_POP1: begin
                    unique case (r_cmd)
                        CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_SWAP, CMD_DUP,
                        CMD_POPSHOW, CMD_PEEK: begin
                            // peek reads the top without popping it
                            r_hit <= (r_sp != '0);
                            if (r_sp == '0) begin
                                r_st <= ST_EMPTY;
                            end else if (r_cmd != CMD_PEEK) begin
                                r_sp <= r_sp - 1'b1;
                            end
                            r_state <= S_GET1;
                        end
                        default: r_state <= S_EXEC;
                    endcase
                end
                S_GET1: begin
                    unique case (r_cmd)
                        CMD_PEEK, CMD_POPSHOW: begin
                            r_has   <= 1'b1;
                            r_shown <= pop_data;
                            r_state <= S_OUT;
                        end
                        CMD_DUP: begin
                            r_a     <= pop_data;
                            r_state <= S_EXEC;
                        end
                        CMD_DIV: begin
                            r_b <= pop_data;
                            // zero divisor stays popped, nothing else changes
                            if (pop_data == '0) begin
                                if (r_st == ST_OK) r_st <= ST_ZERODIV;
                                r_state <= S_OUT;
                            end else begin
                                r_state <= S_POP2;
                            end
                        end
                        default: begin
                            r_b     <= pop_data;
                            r_state <= S_POP2;
                        end
                    endcase
                end
                S_POP2: begin
                    r_hit <= (r_sp != '0);
                    if (r_sp == '0) begin
                        if (r_st == ST_OK) r_st <= ST_EMPTY;
                    end else begin
                        r_sp <= r_sp - 1'b1;
                    end
                    r_state <= S_GET2;
                end
                S_GET2: begin
                    r_a     <= pop_data;
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_state <= S_OUT;
                    unique case (r_cmd)
                        CMD_MUL: begin
                            r_prod  <= prod_w;
                            r_state <= S_MULW;
                        end
                        CMD_DIV: r_state <= S_DIVW;
                        CMD_SWAP, CMD_DUP: begin
                            r_w2    <= r_a;
                            r_state <= S_WR2;
                        end
                        CMD_CLEAR: r_sp <= '0;
                        CMD_PUSH, CMD_ADD, CMD_SUB, CMD_PEEK, CMD_POPSHOW: ;
                        default: r_st <= ST_UNKNOWN;
                    endcase
                end
                S_MULW: r_state <= S_OUT;
                S_DIVW: begin
                    if (div_done) r_state <= S_OUT;
                end
                S_WR2: r_state <= S_OUT;
                S_OUT: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_odata <= {4'd0, 8'(r_sp), r_st, r_has, r_shown};
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            // Advance the pointer on a push, or flag a full stack.
            if (push_req) begin
                if (push_ok) begin
                    r_sp <= r_sp + 1'b1;
                end else if (r_st == ST_OK) begin
                    r_st <= ST_FULL;
                end
            end
        end
    end

    // Hold the result while the receiver stalls.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata));

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state));

    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= PW'(STACK_DEPTH));

endmodule

>>> dv/rpn_stack_calculator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPN stack calculator testbench
// Drives command transactions with random gaps and back-pressure, predicts
// each result with a local stack model and compares every result field.
// ----------------------------------------------------------------------------
module rpn_stack_calculator_tb;
    import rpn_pkg::*;

    localparam int Depth = 128;
    localparam int FracBits = 16;
    localparam logic [3:0] CmdBad = 4'd10;

    typedef struct packed {
        logic [7:0]  depth;
        t_status     status;
        logic        shown;
        logic [31:0] value;
    } t_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // [3:0] command, [35:4] number
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // [31:0] shown_value, [32] value_shown,
                                 // [35:33] status, [43:36] stack_depth

    rpn_stack_calculator dut (.*);

    // Local stack model.
    logic signed [31:0] model_stack [Depth];
    int unsigned        model_sp;
    t_status            model_status;
    t_result            pending_results [$];
    int                 error_count;
    bit                 send_idles;
    bit                 recv_idles;

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic logic signed [31:0] clamp32(logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic void raise(t_status s);
        if (model_status == ST_OK) model_status = s;
    endfunction

    function automatic logic signed [31:0] stack_pop();
        if (model_sp > 0) begin
            model_sp--;
            return model_stack[model_sp];
        end
        raise(ST_EMPTY);
        return '0;
    endfunction

    function automatic void stack_push(logic signed [31:0] v);
        if (model_sp < Depth) begin
            model_stack[model_sp] = v;
            model_sp++;
        end else begin
            raise(ST_FULL);
        end
    endfunction

    // Evaluate one command against the model and queue the expected result.
    function automatic void evaluate_command(logic [3:0] cmd, logic signed [31:0] num);
        logic signed [31:0] a, b, shown;
        logic signed [63:0] p;
        t_result r;
        shown = '0;
        r.shown = 1'b0;
        model_status = ST_OK;
        case (cmd)
            CMD_PUSH: stack_push(num);
            CMD_ADD, CMD_SUB, CMD_MUL: begin
                b = stack_pop();
                a = stack_pop();
                if (cmd == CMD_ADD) stack_push(clamp32(64'(a) + 64'(b)));
                else if (cmd == CMD_SUB) stack_push(clamp32(64'(a) - 64'(b)));
                else begin
                    p = 64'(a) * 64'(b);
                    stack_push(clamp32(p >>> FracBits));  // floor shift
                end
            end
            CMD_DIV: begin
                b = stack_pop();
                if (b == 0) begin
                    raise(ST_ZERODIV);
                end else begin
                    a = stack_pop();
                    p = 64'(a) <<< FracBits;
                    stack_push(clamp32(p / 64'(b)));
                end
            end
            CMD_PEEK: begin
                r.shown = 1'b1;
                if (model_sp > 0) shown = model_stack[model_sp-1];
                else raise(ST_EMPTY);
            end
            CMD_SWAP: begin
                b = stack_pop();
                a = stack_pop();
                stack_push(b);
                stack_push(a);
            end
            CMD_DUP: begin
                a = stack_pop();
                stack_push(a);
                stack_push(a);
            end
            CMD_CLEAR: model_sp = 0;
            CMD_POPSHOW: begin
                r.shown = 1'b1;
                shown = stack_pop();
            end
            default: raise(ST_UNKNOWN);
        endcase
        r.value = shown;
        r.status = model_status;
        r.depth = model_sp[7:0];
        pending_results.push_back(r);
    endfunction

    // Send one command; predict it when the transaction is accepted.
    // tvalid stays high into the next call; idle gaps and draining drop it.
    task automatic send_command(logic [3:0] cmd, logic signed [31:0] num);
        while (send_idles && $urandom_range(99) < 26) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, num, cmd};
        do @(posedge i_clk); while (!s_axis_tready);
        evaluate_command(cmd, num);
    endtask

    // Random back-pressure on the result side.
    always @(posedge i_clk) begin
        m_axis_tready <= !recv_idles || ($urandom_range(99) >= 26);
    end

    // Compare each result transaction with the oldest expectation.
    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[43:0];
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.value !== want.value)
                    $display("%0t: shown_value expected %h actual %h",
                             $time, want.value, got.value);
                if (got.shown !== want.shown)
                    $display("%0t: value_shown expected %b actual %b",
                             $time, want.shown, got.shown);
                if (got.status !== want.status)
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, got.status);
                if (got.depth !== want.depth)
                    $display("%0t: stack_depth expected %0d actual %0d",
                             $time, want.depth, got.depth);
                if (got !== want) error_count++;
            end
        end
    end

    function automatic logic signed [31:0] random_number();
        case ($urandom_range(5))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return '0;
            3: return $signed(32'($urandom_range(4)) << FracBits);
            default: return $urandom;
        endcase
    endfunction

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Each command but push, starting on an empty stack, then two unknown codes.
    task automatic test_empty_stack();
        send_command(CMD_PEEK, 32'sd0);
        send_command(CMD_POPSHOW, 32'sd0);
        send_command(CMD_ADD, 32'sd0);
        send_command(CMD_SWAP, 32'sd0);
        send_command(CMD_CLEAR, 32'sd0);
        send_command(CMD_DUP, 32'sd0);
        send_command(CMD_CLEAR, 32'sd0);
        send_command(CMD_DIV, 32'sd0);
        send_command(CMD_SUB, 32'sd0);
        send_command(CMD_MUL, 32'sd0);
        send_command(4'd15, 32'sd0);
        send_command(CmdBad, 32'sd0);
    endtask

    // Saturation extremes and zero divisor.
    task automatic test_arith_extremes();
        send_command(CMD_CLEAR, 32'sd0);
        send_command(CMD_PUSH, 32'sh7FFF_FFFF);
        send_command(CMD_PUSH, 32'sh7FFF_FFFF);
        send_command(CMD_ADD, 32'sd0);
        send_command(CMD_PUSH, 32'sh8000_0000);
        send_command(CMD_SUB, 32'sd0);
        send_command(CMD_DUP, 32'sd0);
        send_command(CMD_MUL, 32'sd0);
        send_command(CMD_PUSH, -32'sd3);
        send_command(CMD_PUSH, 32'sd0);
        send_command(CMD_DIV, 32'sd0);
        send_command(CMD_PUSH, 32'sh8000_0000);
        send_command(CMD_PUSH, -32'sd1);
        send_command(CMD_DIV, 32'sd0);
        send_command(CMD_PUSH, -32'sd1);
        send_command(CMD_MUL, 32'sd0);
        send_command(CMD_SWAP, 32'sd0);
        send_command(CMD_POPSHOW, 32'sd0);
    endtask

    // Fill to capacity, push on the full stack, then popshow, dup and peek.
    task automatic test_full_stack();
        send_command(CMD_CLEAR, 32'sd0);
        repeat (Depth) send_command(CMD_PUSH, $urandom);
        send_command(CMD_PUSH, 32'sd5);
        send_command(CMD_POPSHOW, 32'sd0);
        send_command(CMD_DUP, 32'sd0);
        send_command(CMD_PEEK, 32'sd0);
        send_command(CMD_CLEAR, 32'sd0);
    endtask

    // Random expression-like traffic: mostly pushes and arithmetic at
    // modest depth, with occasional deep runs and noise.
    task automatic test_random_traffic(int count);
        logic [3:0] cmd;
        for (int i = 0; i < count; i++) begin
            send_idles = !(i >= 300 && i < 600);
            recv_idles = send_idles;
            if (i == 1000) wait_drained();
            if (model_sp < 2 || $urandom_range(99) < 35) cmd = CMD_PUSH;
            else if ($urandom_range(99) < 3) cmd = 4'($urandom_range(10, 15));
            else if (model_sp > 40 && $urandom_range(99) < 5) cmd = CMD_CLEAR;
            else cmd = 4'($urandom_range(1, 9));
            if (model_sp < 5 && cmd == CMD_CLEAR) cmd = CMD_DUP;
            send_command(cmd, random_number());
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        model_sp = 0;
        error_count = 0;
        send_idles = 1'b1;
        recv_idles = 1'b1;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_stack();
        test_arith_extremes();
        test_full_stack();
        test_random_traffic(1800);
        wait_drained();
        repeat (100) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

endmodule

>>> filelist.f
rtl/rpn_pkg.sv
rtl/rpn_ram.sv
rtl/rpn_div.sv
rtl/rpn_stack_calculator.sv
dv/rpn_stack_calculator_tb.sv
